// ===== sv/frp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the framed packet receiver.
// Depends on nothing; every other file of the block refers to it by scoped names.
package frp_pkg;

  localparam int MAX_LEN_DEF = 32;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 6;
  localparam int IDX_W     = 5;
  localparam int EV_W      = 3;
  localparam int CFG_IDX_W = 2;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN,
    PH_DATA,
    PH_SUM,
    PH_TAIL,
    PH_HELD
  } phase_t;

  // Result event codes.
  localparam logic [EV_W-1:0] EV_CONSUMED   = 3'd0;
  localparam logic [EV_W-1:0] EV_FRAME_DONE = 3'd1;
  localparam logic [EV_W-1:0] EV_BAD_LEN    = 3'd2;
  localparam logic [EV_W-1:0] EV_BAD_SUM    = 3'd3;
  localparam logic [EV_W-1:0] EV_BAD_TAIL   = 3'd4;
  localparam logic [EV_W-1:0] EV_DROPPED    = 3'd5;
  localparam logic [EV_W-1:0] EV_PAYLOAD    = 3'd6;
  localparam logic [EV_W-1:0] EV_NO_FRAME   = 3'd7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HEAD        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd2;

  localparam logic [BYTE_W-1:0] HEAD_RST        = 8'hAA;
  localparam logic [BYTE_W-1:0] TAIL_RST        = 8'h55;
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 6'd32;

  // Command from the parser to the output sequencer. A stream command plays
  // back flen payload bytes; any other command yields one result beat.
  typedef struct packed {
    logic              stream;
    logic [EV_W-1:0]   ev;
    logic [LEN_W-1:0]  flen;
  } cmd_t;

  // Payload store write request from the parser.
  typedef struct packed {
    logic              en;
    logic [LEN_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } store_wr_t;

  // One result beat.
  typedef struct packed {
    logic [EV_W-1:0]   ev;
    logic [BYTE_W-1:0] data;
    logic [IDX_W-1:0]  idx;
    logic [LEN_W-1:0]  flen;
    logic              last;
  } res_t;

endpackage

// ===== sv/frp_front.sv =====
`timescale 1ns / 1ps
// Front end of the framed packet receiver: configuration registers, frame parser
// and payload store writes. Uses frp_pkg; feeds frp_cmd_queue and frp_back.
module frp_front #(
  parameter int MAX_LEN = frp_pkg::MAX_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic                           req_type,
  input  logic [frp_pkg::BYTE_W-1:0]     rx_byte,
  input  logic                           cfg_we,
  input  logic [frp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frp_pkg::BYTE_W-1:0]     cfg_data,
  input  logic                           q_full,
  input  logic                           stream_done,
  output logic                           cmd_push,
  output frp_pkg::cmd_t                  cmd,
  output frp_pkg::store_wr_t             wr
);

  logic [frp_pkg::BYTE_W-1:0] head_byte;
  logic [frp_pkg::BYTE_W-1:0] tail_byte;
  logic [frp_pkg::LEN_W-1:0]  max_payload;

  frp_pkg::phase_t            phase, phase_next;
  logic [frp_pkg::LEN_W-1:0]  expected_count, expected_count_next;
  logic [frp_pkg::LEN_W-1:0]  received_count, received_count_next;
  logic [frp_pkg::BYTE_W-1:0] running_sum, running_sum_next;
  logic [frp_pkg::LEN_W-1:0]  held_length, held_length_next;
  logic                       take_busy, take_busy_next;

  logic                       accept;
  logic [frp_pkg::BYTE_W-1:0] limit;
  logic                       len_ok;
  logic [frp_pkg::LEN_W-1:0]  rcv_inc;
  logic [frp_pkg::BYTE_W-1:0] sum_inc;

  // A take in flight blocks new beats so the store is not overwritten
  // while it is being played back.
  assign full     = q_full || take_busy;
  assign accept   = push && !full;
  assign cmd_push = accept;

  assign limit   = (8'(max_payload) < 8'(MAX_LEN)) ? {2'b00, max_payload} : 8'(MAX_LEN);
  assign len_ok  = (rx_byte <= limit);
  assign rcv_inc = received_count + 6'd1;
  assign sum_inc = running_sum + rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte   <= frp_pkg::HEAD_RST;
      tail_byte   <= frp_pkg::TAIL_RST;
      max_payload <= frp_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        frp_pkg::REG_HEAD:        head_byte   <= cfg_data;
        frp_pkg::REG_TAIL:        tail_byte   <= cfg_data;
        frp_pkg::REG_MAX_PAYLOAD: max_payload <= cfg_data[frp_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (accept) begin
      if (req_type) begin
        if (phase == frp_pkg::PH_HELD) phase_next = frp_pkg::PH_HUNT;
      end else begin
        case (phase)
          frp_pkg::PH_HUNT: begin
            if (rx_byte == head_byte) phase_next = frp_pkg::PH_LEN;
          end
          frp_pkg::PH_LEN: begin
            if (!len_ok) phase_next = frp_pkg::PH_HUNT;
            else if (rx_byte == 8'd0) phase_next = frp_pkg::PH_SUM;
            else phase_next = frp_pkg::PH_DATA;
          end
          frp_pkg::PH_DATA: begin
            if (rcv_inc >= expected_count) phase_next = frp_pkg::PH_SUM;
          end
          frp_pkg::PH_SUM: begin
            phase_next = (rx_byte == running_sum) ? frp_pkg::PH_TAIL : frp_pkg::PH_HUNT;
          end
          frp_pkg::PH_TAIL: begin
            phase_next = (rx_byte == tail_byte) ? frp_pkg::PH_HELD : frp_pkg::PH_HUNT;
          end
          frp_pkg::PH_HELD: ;
          default: phase_next = frp_pkg::PH_HUNT;
        endcase
      end
    end
  end

  // Commands, store writes and counter updates.
  always_comb begin
    cmd                 = '0;
    cmd.ev              = frp_pkg::EV_CONSUMED;
    wr                  = '0;
    wr.addr             = received_count;
    wr.data             = rx_byte;
    expected_count_next = expected_count;
    received_count_next = received_count;
    running_sum_next    = running_sum;
    held_length_next    = held_length;
    if (req_type) begin
      if (phase != frp_pkg::PH_HELD) begin
        cmd.ev = frp_pkg::EV_NO_FRAME;
      end else if (held_length == '0) begin
        cmd.ev = frp_pkg::EV_PAYLOAD;
      end else begin
        cmd.ev     = frp_pkg::EV_PAYLOAD;
        cmd.stream = 1'b1;
        cmd.flen   = held_length;
      end
    end else begin
      case (phase)
        frp_pkg::PH_HUNT: begin
          if (rx_byte == head_byte) received_count_next = '0;
        end
        frp_pkg::PH_LEN: begin
          if (len_ok) begin
            expected_count_next = rx_byte[frp_pkg::LEN_W-1:0];
            received_count_next = '0;
            running_sum_next    = rx_byte;
          end else begin
            cmd.ev = frp_pkg::EV_BAD_LEN;
          end
        end
        frp_pkg::PH_DATA: begin
          wr.en               = accept && ({1'b0, received_count} < 7'(MAX_LEN));
          running_sum_next    = sum_inc;
          received_count_next = rcv_inc;
        end
        frp_pkg::PH_SUM: begin
          if (rx_byte != running_sum) cmd.ev = frp_pkg::EV_BAD_SUM;
        end
        frp_pkg::PH_TAIL: begin
          if (rx_byte == tail_byte) begin
            cmd.ev           = frp_pkg::EV_FRAME_DONE;
            cmd.flen         = expected_count;
            held_length_next = expected_count;
          end else begin
            cmd.ev = frp_pkg::EV_BAD_TAIL;
          end
        end
        frp_pkg::PH_HELD: begin
          cmd.ev   = frp_pkg::EV_DROPPED;
          cmd.flen = held_length;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    take_busy_next = take_busy;
    if (stream_done) take_busy_next = 1'b0;
    if (accept && cmd.stream) take_busy_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= frp_pkg::PH_HUNT;
      expected_count <= '0;
      received_count <= '0;
      running_sum    <= '0;
      held_length    <= '0;
      take_busy      <= 1'b0;
    end else begin
      take_busy <= take_busy_next;
      phase     <= phase_next;
      if (accept) begin
        expected_count <= expected_count_next;
        received_count <= received_count_next;
        running_sum    <= running_sum_next;
        held_length    <= held_length_next;
      end
    end
  end

endmodule

// ===== sv/frp_cmd_queue.sv =====
`timescale 1ns / 1ps
// Two-entry command queue between the parser and the output sequencer.
// Uses frp_pkg for the command type.
module frp_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  frp_pkg::cmd_t wr_cmd,
  output logic          q_full,
  input  logic          rd_en,
  output logic          q_valid,
  output frp_pkg::cmd_t rd_cmd
);

  frp_pkg::cmd_t entries [2];
  logic          wptr, rptr;
  logic [1:0]    count;

  assign q_full  = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign rd_cmd  = entries[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) entries[wptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_en) wptr <= ~wptr;
      if (rd_en) rptr <= ~rptr;
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

// ===== sv/frp_back.sv =====
`timescale 1ns / 1ps
// Back end of the framed packet receiver: payload store, playback sequencer
// and result queue. Uses frp_pkg; takes commands from frp_cmd_queue.
module frp_back #(
  parameter int MAX_LEN = frp_pkg::MAX_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  frp_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  input  frp_pkg::store_wr_t wr,
  output logic               stream_done,
  input  logic               pop,
  output logic               empty,
  output frp_pkg::res_t      out_res
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [frp_pkg::BYTE_W-1:0] mem [MAX_LEN];
  logic [frp_pkg::BYTE_W-1:0] rdata;

  logic                       streaming;
  logic [frp_pkg::LEN_W-1:0]  idx;
  logic [frp_pkg::LEN_W-1:0]  len;

  logic                       s1_valid;
  logic                       s1_stream;
  frp_pkg::res_t              s1;
  frp_pkg::res_t              push_res;

  frp_pkg::res_t              ofifo [4];
  logic [1:0]                 owp, orp;
  logic [2:0]                 ocount;

  logic                       can_issue;
  logic                       issue_rd;
  logic                       issue_single;
  logic                       last_beat;
  logic                       pop_out;

  // Room is reserved for the beat already in the read stage.
  assign can_issue    = (ocount + {2'b00, s1_valid}) < 3'd3;
  assign issue_rd     = streaming && can_issue;
  assign last_beat    = ((idx + 6'd1) == len);
  assign q_pop        = !streaming && q_valid && (q_cmd.stream || can_issue);
  assign issue_single = q_pop && !q_cmd.stream;
  assign stream_done  = issue_rd && last_beat;

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr[AW-1:0]] <= wr.data;
    if (issue_rd) rdata <= mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      streaming <= 1'b0;
      idx       <= '0;
      len       <= '0;
      s1_valid  <= 1'b0;
    end else begin
      s1_valid <= issue_rd || issue_single;
      if (q_pop && q_cmd.stream) begin
        streaming <= 1'b1;
        idx       <= '0;
        len       <= q_cmd.flen;
      end else if (issue_rd) begin
        idx <= idx + 6'd1;
        if (last_beat) streaming <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue_rd) begin
      s1_stream <= 1'b1;
      s1.ev     <= frp_pkg::EV_PAYLOAD;
      s1.data   <= '0;
      s1.idx    <= idx[frp_pkg::IDX_W-1:0];
      s1.flen   <= len;
      s1.last   <= last_beat;
    end else if (issue_single) begin
      s1_stream <= 1'b0;
      s1.ev     <= q_cmd.ev;
      s1.data   <= '0;
      s1.idx    <= '0;
      s1.flen   <= q_cmd.flen;
      s1.last   <= 1'b1;
    end
  end

  always_comb begin
    push_res      = s1;
    push_res.data = s1_stream ? rdata : s1.data;
  end

  assign pop_out = pop && !empty;
  assign empty   = (ocount == 3'd0);
  assign out_res = ofifo[orp];

  always_ff @(posedge clk) begin
    if (s1_valid) ofifo[owp] <= push_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp    <= '0;
      orp    <= '0;
      ocount <= '0;
    end else begin
      if (s1_valid) owp <= owp + 2'd1;
      if (pop_out) orp <= orp + 2'd1;
      ocount <= ocount + {2'b00, s1_valid} - {2'b00, pop_out};
    end
  end

  // A beat leaving the read stage always finds a free result slot.
  a_room_for_beat: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (ocount < 3'd4))
    else $error("result queue overflow");

  // The parser must never write the store during playback.
  a_no_write_in_stream: assert property (@(posedge clk) disable iff (rst)
    !(wr.en && streaming))
    else $error("payload store written during playback");

  a_stream_ends: assert property (@(posedge clk) disable iff (rst)
    stream_done |=> !streaming)
    else $error("playback did not end after its last beat");

  a_issue_lands: assert property (@(posedge clk) disable iff (rst)
    issue_rd |=> s1_valid)
    else $error("issued payload read produced no beat");

endmodule

// ===== sv/framed_packet_receiver.sv =====
`timescale 1ns / 1ps
// Framed packet receiver: top level tying parser, command queue and playback together.
// Depends on frp_pkg, frp_front, frp_cmd_queue and frp_back.
//
// Usage. The input side is a queue: drive req_type and rx_byte with push high; the
// beat is taken at a clock edge where full is low. req_type 0 delivers a received
// byte to the frame parser (head, length, payload, checksum, tail), req_type 1 asks
// for the held frame. The result side is a queue too: while empty is low the oldest
// result beat sits on event_res, data_byte, byte_index, payload_len and last, and
// pop takes it. Every received byte yields exactly one result beat with last set; a
// take of a held frame yields one beat per payload byte, last on the final one, or one
// beat if the frame is empty. A single result beat passes the command queue, the read
// stage and the result queue; the first payload beat of a take also waits for the
// playback sequencer to start. Received bytes are taken one per cycle as long as
// results are drained. During a take, full stays high from acceptance until the last
// payload byte has been read from the payload store, so that a new frame cannot
// overwrite the store; playback meanwhile runs one beat per cycle while results drain.
// If the receiver stalls (pop low), the result queue and the command queue fill and
// full rises; nothing is lost. The configuration port writes head_byte, tail_byte or
// max_payload, as cfg_index selects, and must only be used while the block is idle.
// Synchronous reset returns the parser to hunting for a head byte, restores the
// register defaults and empties both queues; the payload store is not cleared.
module framed_packet_receiver #(
  parameter int MAX_LEN = frp_pkg::MAX_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input beats.
  input  logic                          push,
  output logic                          full,
  input  logic                          req_type,
  input  logic [frp_pkg::BYTE_W-1:0]    rx_byte,
  // Result beats.
  output logic                          empty,
  input  logic                          pop,
  output logic [frp_pkg::EV_W-1:0]      event_res,
  output logic [frp_pkg::BYTE_W-1:0]    data_byte,
  output logic [frp_pkg::IDX_W-1:0]     byte_index,
  output logic [frp_pkg::LEN_W-1:0]     payload_len,
  output logic                          last,
  // Configuration writes.
  input  logic                          cfg_we,
  input  logic [frp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [frp_pkg::BYTE_W-1:0]    cfg_data
);

  logic               q_full;
  logic               q_valid;
  logic               q_pop;
  logic               cmd_push;
  logic               stream_done;
  frp_pkg::cmd_t      cmd;
  frp_pkg::cmd_t      q_cmd;
  frp_pkg::store_wr_t wr;
  frp_pkg::res_t      out_res;

  // Parser: classifies each input beat into a command and fills the store.
  frp_front #(
    .MAX_LEN(MAX_LEN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .rx_byte    (rx_byte),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .stream_done(stream_done),
    .cmd_push   (cmd_push),
    .cmd        (cmd),
    .wr         (wr)
  );

  // Short queue that lets the parser and the playback side stall independently.
  frp_cmd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (cmd_push),
    .wr_cmd (cmd),
    .q_full (q_full),
    .rd_en  (q_pop),
    .q_valid(q_valid),
    .rd_cmd (q_cmd)
  );

  // Playback: turns commands into result beats, streaming payload from the store.
  frp_back #(
    .MAX_LEN(MAX_LEN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .wr         (wr),
    .stream_done(stream_done),
    .pop        (pop),
    .empty      (empty),
    .out_res    (out_res)
  );

  assign event_res   = out_res.ev;
  assign data_byte   = out_res.data;
  assign byte_index  = out_res.idx;
  assign payload_len = out_res.flen;
  assign last        = out_res.last;

endmodule

// ===== test/frp_result_check.sv =====
`timescale 1ns / 1ps
// Result checker for the framed packet receiver: follows register writes and input beats,
// works out the result beats the parser owes, and compares them with the popped beats.
// Depends on frp_pkg only.
module frp_result_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic                          full,
  input  logic                          req_type,
  input  logic [frp_pkg::BYTE_W-1:0]    rx_byte,
  input  logic                          empty,
  input  logic                          pop,
  input  logic [frp_pkg::EV_W-1:0]      event_res,
  input  logic [frp_pkg::BYTE_W-1:0]    data_byte,
  input  logic [frp_pkg::IDX_W-1:0]     byte_index,
  input  logic [frp_pkg::LEN_W-1:0]     payload_len,
  input  logic                          last,
  input  logic                          cfg_we,
  input  logic [frp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [frp_pkg::BYTE_W-1:0]    cfg_data,
  output int                            mismatches = 0,
  output int                            owed = 0
);

  frp_pkg::phase_t            parse_ph;
  logic [frp_pkg::LEN_W-1:0]  want_len;
  logic [frp_pkg::LEN_W-1:0]  got_len;
  logic [frp_pkg::LEN_W-1:0]  held_len;
  logic [frp_pkg::LEN_W-1:0]  max_len_reg;
  logic [frp_pkg::BYTE_W-1:0] sum_acc;
  logic [frp_pkg::BYTE_W-1:0] head_reg;
  logic [frp_pkg::BYTE_W-1:0] tail_reg;
  logic [frp_pkg::BYTE_W-1:0] payload_mem [frp_pkg::MAX_LEN_DEF];
  frp_pkg::res_t              owed_beats [$];
  int                         fail_cnt = 0;

  task owe(input logic [frp_pkg::EV_W-1:0] ev, input logic [frp_pkg::BYTE_W-1:0] data,
           input logic [frp_pkg::IDX_W-1:0] idx, input logic [frp_pkg::LEN_W-1:0] flen,
           input logic lst);
    frp_pkg::res_t r;
    r.ev   = ev;
    r.data = data;
    r.idx  = idx;
    r.flen = flen;
    r.last = lst;
    owed_beats.push_back(r);
  endtask

  // Advances the parser by one accepted input beat and queues the beats it owes.
  task parse_beat(input logic take, input logic [frp_pkg::BYTE_W-1:0] b);
    logic [frp_pkg::LEN_W-1:0] cap;
    logic [frp_pkg::EV_W-1:0]  ev;
    logic [frp_pkg::LEN_W-1:0] flen;
    ev = frp_pkg::EV_CONSUMED;
    flen = '0;
    if (take) begin
      if (parse_ph != frp_pkg::PH_HELD) begin
        owe(frp_pkg::EV_NO_FRAME, '0, '0, '0, 1'b1);
        return;
      end
      parse_ph = frp_pkg::PH_HUNT;
      if (held_len == '0) begin
        owe(frp_pkg::EV_PAYLOAD, '0, '0, '0, 1'b1);
        return;
      end
      for (int i = 0; i < held_len; i++)
        owe(frp_pkg::EV_PAYLOAD, payload_mem[i], frp_pkg::IDX_W'(i), held_len,
            (i + 1) == held_len);
      return;
    end
    case (parse_ph)
      frp_pkg::PH_HUNT: begin
        if (b == head_reg) begin
          parse_ph = frp_pkg::PH_LEN;
          got_len = '0;
        end
      end
      frp_pkg::PH_LEN: begin
        cap = (max_len_reg < frp_pkg::MAX_LEN_DEF) ? max_len_reg
                                                   : frp_pkg::LEN_W'(frp_pkg::MAX_LEN_DEF);
        if (b <= cap) begin
          want_len = b[frp_pkg::LEN_W-1:0];
          got_len = '0;
          sum_acc = b;
          parse_ph = (b == '0) ? frp_pkg::PH_SUM : frp_pkg::PH_DATA;
        end else begin
          ev = frp_pkg::EV_BAD_LEN;
          parse_ph = frp_pkg::PH_HUNT;
        end
      end
      frp_pkg::PH_DATA: begin
        if (got_len < frp_pkg::MAX_LEN_DEF) payload_mem[got_len] = b;
        sum_acc = sum_acc + b;
        got_len = got_len + 1'b1;
        if (got_len >= want_len) parse_ph = frp_pkg::PH_SUM;
      end
      frp_pkg::PH_SUM: begin
        if (b == sum_acc) begin
          parse_ph = frp_pkg::PH_TAIL;
        end else begin
          ev = frp_pkg::EV_BAD_SUM;
          parse_ph = frp_pkg::PH_HUNT;
        end
      end
      frp_pkg::PH_TAIL: begin
        if (b == tail_reg) begin
          held_len = want_len;
          parse_ph = frp_pkg::PH_HELD;
          ev = frp_pkg::EV_FRAME_DONE;
          flen = want_len;
        end else begin
          ev = frp_pkg::EV_BAD_TAIL;
          parse_ph = frp_pkg::PH_HUNT;
        end
      end
      frp_pkg::PH_HELD: begin
        ev = frp_pkg::EV_DROPPED;
        flen = held_len;
      end
      default: parse_ph = frp_pkg::PH_HUNT;
    endcase
    owe(ev, '0, '0, flen, 1'b1);
  endtask

  function void compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  task check_beat();
    frp_pkg::res_t want;
    if (owed_beats.size() == 0) begin
      $error("unexpected result beat: event_res %0d data_byte %0d", event_res, data_byte);
      fail_cnt++;
      return;
    end
    want = owed_beats.pop_front();
    compare_field("event_res", 8'(want.ev), 8'(event_res));
    compare_field("data_byte", want.data, data_byte);
    compare_field("byte_index", 8'(want.idx), 8'(byte_index));
    compare_field("payload_len", 8'(want.flen), 8'(payload_len));
    compare_field("last", 8'(want.last), 8'(last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      head_reg = frp_pkg::HEAD_RST;
      tail_reg = frp_pkg::TAIL_RST;
      max_len_reg = frp_pkg::MAX_PAYLOAD_RST;
      parse_ph = frp_pkg::PH_HUNT;
      want_len = '0;
      got_len = '0;
      sum_acc = '0;
      held_len = '0;
      owed_beats.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          frp_pkg::REG_HEAD:        head_reg = cfg_data;
          frp_pkg::REG_TAIL:        tail_reg = cfg_data;
          frp_pkg::REG_MAX_PAYLOAD: max_len_reg = cfg_data[frp_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
      if (pop && !empty) check_beat();
      if (push && !full) parse_beat(req_type, rx_byte);
    end
    mismatches <= fail_cnt;
    owed <= owed_beats.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Top of the framed packet receiver testbench: clock, reset, register setup, stimulus,
// receiver stalls, watchdog and verdict. Depends on frp_pkg, framed_packet_receiver
// and frp_result_check, which predicts and compares the result beats.
module tb;

  localparam int STALL_CYCLES   = 400;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 3000;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          push;
  logic                          full;
  logic                          req_type;
  logic [frp_pkg::BYTE_W-1:0]    rx_byte;
  logic                          empty;
  logic                          pop;
  logic [frp_pkg::EV_W-1:0]      event_res;
  logic [frp_pkg::BYTE_W-1:0]    data_byte;
  logic [frp_pkg::IDX_W-1:0]     byte_index;
  logic [frp_pkg::LEN_W-1:0]     payload_len;
  logic                          last;
  logic                          cfg_we;
  logic [frp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [frp_pkg::BYTE_W-1:0]    cfg_data;

  int mismatches;
  int owed;

  // Idle rates in percent; the main process sets them, the driving processes read them.
  int tx_idle_pct = 34;
  int rx_idle_pct = 45;
  // Toggling hold_req asks the receiver process for one long stall.
  bit hold_req = 1'b0;
  bit hold_ack = 1'b0;
  int beats_sent = 0;
  int quiet_cycles = 0;

  // Copies of the current register settings, used to build frames that get far into
  // the parser. len_cap is the effective length limit after the cap at 32.
  logic [7:0] head_val;
  logic [7:0] tail_val;
  int         len_cap;

  always #2 clk = ~clk;

  framed_packet_receiver i_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .req_type     (req_type),
    .rx_byte      (rx_byte),
    .empty        (empty),
    .pop          (pop),
    .event_res    (event_res),
    .data_byte    (data_byte),
    .byte_index   (byte_index),
    .payload_len  (payload_len),
    .last         (last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  frp_result_check i_result_check (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .req_type     (req_type),
    .rx_byte      (rx_byte),
    .empty        (empty),
    .pop          (pop),
    .event_res    (event_res),
    .data_byte    (data_byte),
    .byte_index   (byte_index),
    .payload_len  (payload_len),
    .last         (last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .owed         (owed)
  );

  // Offers one input beat and returns at the edge that accepts it. Random idle cycles
  // come first, and push stays high afterwards so back-to-back beats need no gap.
  task offer(input logic take, input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    req_type <= take;
    rx_byte <= b;
    do @(posedge clk); while (full);
    beats_sent++;
  endtask

  // A take request; its byte field is ignored by the block, so it carries noise.
  task take_frame();
    offer(1'b1, 8'($urandom_range(255)));
  endtask

  // Stops offering and waits until every owed result beat has been popped. The owed
  // count is registered, hence the edge before the first look, and the extra cycles at
  // the end let anything the block should not produce show up.
  task drain();
    push <= 1'b0;
    do @(posedge clk); while (owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges. Only called while the block is idle.
  task set_regs(input logic [7:0] h, input logic [7:0] t, input logic [7:0] m);
    cfg_we <= 1'b1;
    cfg_index <= frp_pkg::REG_HEAD;
    cfg_data <= h;
    @(posedge clk);
    cfg_index <= frp_pkg::REG_TAIL;
    cfg_data <= t;
    @(posedge clk);
    cfg_index <= frp_pkg::REG_MAX_PAYLOAD;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    head_val = h;
    tail_val = t;
    len_cap = (m[5:0] < 32) ? int'(m[5:0]) : 32;
  endtask

  // Sends one frame with random content. Most frames are well formed; a few carry a
  // length above the limit, a wrong checksum or a wrong tail. A good frame may be
  // followed by bytes that the block must drop while it holds the frame, and is
  // usually taken afterwards.
  task send_frame();
    int         len;
    int         flaw;
    logic [7:0] sum;
    logic [7:0] b;
    flaw = $urandom_range(19);
    if ($urandom_range(9) == 0) len = len_cap;
    else len = $urandom_range((len_cap < 6) ? len_cap : 6, 0);
    offer(1'b0, head_val);
    if (flaw == 0) begin
      offer(1'b0, 8'($urandom_range(255, len_cap + 1)));
      return;
    end
    sum = 8'(len);
    offer(1'b0, 8'(len));
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      sum = sum + b;
      offer(1'b0, b);
    end
    if (flaw == 1) begin
      offer(1'b0, sum ^ 8'($urandom_range(255, 1)));
      return;
    end
    offer(1'b0, sum);
    if (flaw == 2) begin
      offer(1'b0, tail_val ^ 8'($urandom_range(255, 1)));
      return;
    end
    offer(1'b0, tail_val);
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(3, 1)) offer(1'b0, 8'($urandom_range(255)));
    end
    if ($urandom_range(9) != 0) take_frame();
  endtask

  // Random traffic: mostly frames, with stray takes and noise bytes between them.
  task run_random(input int count);
    int start;
    int pick;
    start = beats_sent;
    while (beats_sent - start < count) begin
      pick = $urandom_range(99);
      if (pick < 70) send_frame();
      else if (pick < 80) take_frame();
      else offer(1'b0, 8'($urandom_range(255)));
    end
  endtask

  // Receiver side. It pops at random unless a long stall was asked for, which it
  // counts out itself while the sender keeps offering, so that both queues of the
  // block fill up and full has to rise.
  initial begin
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        pop <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: ends the run when no beat has moved on either side for too long.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    push = 1'b0;
    req_type = 1'b0;
    rx_byte = '0;
    cfg_we = 1'b0;
    cfg_index = frp_pkg::REG_HEAD;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part with the reset values written explicitly.
    set_regs(frp_pkg::HEAD_RST, frp_pkg::TAIL_RST, 8'(frp_pkg::MAX_PAYLOAD_RST));
    take_frame();                          // nothing held yet
    offer(1'b0, head_val);                 // zero-length frame: tail right after checksum
    offer(1'b0, 8'h00);
    offer(1'b0, 8'h00);
    offer(1'b0, tail_val);
    offer(1'b0, 8'hFF);                    // dropped while the frame is held
    take_frame();                          // empty frame comes out as a single beat
    offer(1'b0, head_val);                 // one past the length limit
    offer(1'b0, 8'd33);
    offer(1'b0, head_val);                 // largest length byte
    offer(1'b0, 8'hFF);
    offer(1'b0, head_val);                 // checksum off in two bits
    offer(1'b0, 8'h01);
    offer(1'b0, 8'h80);
    offer(1'b0, 8'h00);
    offer(1'b0, head_val);                 // good checksum, wrong tail
    offer(1'b0, 8'h01);
    offer(1'b0, 8'h7F);
    offer(1'b0, 8'h80);
    offer(1'b0, 8'h00);
    offer(1'b0, head_val);                 // two payload bytes at both extremes
    offer(1'b0, 8'h02);
    offer(1'b0, 8'hFF);
    offer(1'b0, 8'h00);
    offer(1'b0, 8'h01);
    offer(1'b0, tail_val);
    take_frame();
    drain();

    // Low extremes: only zero-length frames pass the length check.
    set_regs(8'h00, 8'hFF, 8'h00);
    run_random(70);
    drain();

    // Swap the idle rates. All-ones register data puts max_payload above the cap at
    // 32, and the receiver stalls long enough for full to rise.
    tx_idle_pct = 45;
    rx_idle_pct = 34;
    set_regs(8'hFF, 8'h00, 8'hFF);
    hold_req = ~hold_req;
    run_random(110);
    drain();

    // Random settings; the upper bits of the max_payload write must be ignored.
    set_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
             8'($urandom_range(32, 1)) | 8'($urandom_range(3) << 6));
    run_random(110);
    drain();

    // No idling at all, back on the reset values.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_regs(frp_pkg::HEAD_RST, frp_pkg::TAIL_RST, 8'(frp_pkg::MAX_PAYLOAD_RST));
    run_random(110);
    drain();

    if (mismatches == 0 && owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/frp_pkg.sv
sv/frp_front.sv
sv/frp_cmd_queue.sv
sv/frp_back.sv
sv/framed_packet_receiver.sv
test/frp_result_check.sv
test/tb.sv
